### sv/wamf_pkg.sv
// ============================================================================
// wamf_pkg
// Shared constants, codes and helpers of the window average / median filter.
// ============================================================================
`default_nettype none

package wamf_pkg;

    // Ring depth and derived widths.
    localparam int DEPTH   = 64;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int FILL_W  = $clog2(DEPTH + 1);
    localparam int DATA_W  = 32;
    localparam int WIN_W   = 8;
    localparam int CNT_W   = (FILL_W > WIN_W) ? FILL_W : WIN_W;
    localparam int ACC_W   = DATA_W + WIN_W;
    localparam int BIT_W   = $clog2(ACC_W);
    localparam int MODE_W  = 2;

    // Configuration port.
    localparam int APB_ADDR_W = 4;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = APB_ADDR_W - 2;

    localparam logic [REG_IDX_W-1:0] REG_FILTER_MODE   = REG_IDX_W'(0);
    localparam logic [REG_IDX_W-1:0] REG_AVG_WINDOW    = REG_IDX_W'(1);
    localparam logic [REG_IDX_W-1:0] REG_MEDIAN_WINDOW = REG_IDX_W'(2);

    // Filter modes; the unused code behaves as pass through.
    localparam logic [MODE_W-1:0] MODE_PASS   = MODE_W'(0);
    localparam logic [MODE_W-1:0] MODE_AVG    = MODE_W'(1);
    localparam logic [MODE_W-1:0] MODE_MEDIAN = MODE_W'(2);

    // Step one slot back in the ring, wrapping at the bottom.
    function automatic logic [ADDR_W-1:0] older_slot(input logic [ADDR_W-1:0] pos);
        return (pos == '0) ? ADDR_W'(DEPTH - 1) : pos - ADDR_W'(1);
    endfunction

endpackage

`default_nettype wire

### sv/window_average_median_filter.sv
// ============================================================================
// window_average_median_filter
// Ring of recent Q16.16 samples with pass-through, moving-average or median
// output, computed by a small sequencer around one shared add/subtract unit.
// ============================================================================
//
//  Channel   Direction  Beat contents
//  s_axis    in         tdata: sample[31:0]     tuser: restart[0]
//  m_axis    out        tdata: filtered[31:0]   tuser: used_latest[0]
//  APB       in/out     regs: 0x0 filter_mode, 0x4 avg_window, 0x8 median_window
//
//  One sample at a time; s_axis is ready only while the sequencer is idle.
//  Pass through, zero window or too few samples: straight to the output register.
//  Moving average over W entries: a read loop, then a 40-step divider.
//  Median over W entries: one rescan of the window per candidate.
//  A result waits in the output register while the next sample is taken in.
//  Synchronous active-low reset empties the ring (fill count and position only).
//
`default_nettype none

module window_average_median_filter (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    // Input stream
    input  wire logic                              i_s_axis_tvalid,
    output logic                                   o_s_axis_tready,
    input  wire logic [31:0]                       i_s_axis_tdata,  // sample[31:0]
    input  wire logic [0:0]                        i_s_axis_tuser,  // restart[0]
    // Output stream
    output logic                                   o_m_axis_tvalid,
    input  wire logic                              i_m_axis_tready,
    output logic      [31:0]                       o_m_axis_tdata,  // filtered[31:0]
    output logic      [0:0]                        o_m_axis_tuser,  // used_latest[0]
    // Configuration
    input  wire logic                              psel,
    input  wire logic                              penable,
    input  wire logic                              pwrite,
    input  wire logic [wamf_pkg::APB_ADDR_W-1:0]   paddr,
    input  wire logic [wamf_pkg::APB_DATA_W-1:0]   pwdata,
    output logic      [wamf_pkg::APB_DATA_W-1:0]   prdata,
    output logic                                   pready
);

    import wamf_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SUM,
        S_ABS,
        S_DIV,
        S_SIGN,
        S_MCAND,
        S_MLOAD,
        S_MSCAN,
        S_OUT
    } t_state;

    t_state              r_state;

    // Configuration registers
    logic [MODE_W-1:0]   r_filter_mode;
    logic [WIN_W-1:0]    r_avg_window;
    logic [WIN_W-1:0]    r_median_window;

    // Ring bookkeeping
    logic [ADDR_W-1:0]   r_wp;
    logic [FILL_W-1:0]   r_fill;
    logic [ADDR_W-1:0]   r_newest;

    // Work registers
    logic [WIN_W-1:0]    r_win;
    logic [WIN_W-1:0]    r_iss;
    logic [WIN_W-1:0]    r_rcv;
    logic                r_dv;
    logic [ADDR_W-1:0]   r_rptr;
    logic [ADDR_W-1:0]   r_cptr;
    logic [DATA_W-1:0]   r_cand;
    logic [WIN_W-1:0]    r_less;
    logic [WIN_W-1:0]    r_eq;
    logic [ACC_W-1:0]    r_acc;
    logic [WIN_W-1:0]    r_rem;
    logic [BIT_W-1:0]    r_bit;
    logic                r_neg;
    logic [DATA_W-1:0]   r_res;
    logic                r_latest;

    // Output register
    logic                r_out_valid;
    logic [DATA_W-1:0]   r_out_data;
    logic                r_out_latest;

    // Combinational helpers
    logic                in_accept;
    logic                in_restart;
    logic [ADDR_W-1:0]   in_wp;
    logic [FILL_W-1:0]   in_fill;
    logic [FILL_W-1:0]   in_fill_n;
    logic [WIN_W-1:0]    med_win;
    logic                issue;
    logic [ADDR_W-1:0]   ram_raddr;
    logic [DATA_W-1:0]   ram_rdata;
    logic [WIN_W:0]      rem_s;
    logic                med_hit;
    logic [WIN_W:0]      less_eq;
    logic [WIN_W-1:0]    med_k;
    logic                out_free;
    logic                cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;
    logic [DATA_W-1:0]   n_res;
    logic                n_latest;
    t_state              n_state;

    // Shared add/subtract unit
    logic signed [ACC_W:0] alu_a;
    logic signed [ACC_W:0] alu_b;
    logic                  alu_sub;
    logic signed [ACC_W:0] alu_y;

    assign o_s_axis_tready = (r_state == S_IDLE);
    assign in_accept       = i_s_axis_tvalid && o_s_axis_tready;
    assign in_restart      = i_s_axis_tuser[0];
    assign in_wp           = in_restart ? '0 : r_wp;
    assign in_fill         = in_restart ? '0 : r_fill;
    assign in_fill_n       = (in_fill < FILL_W'(DEPTH)) ? in_fill + FILL_W'(1) : in_fill;

    assign med_win = (CNT_W'(r_median_window) > CNT_W'(DEPTH)) ? WIN_W'(DEPTH)
                                                                : r_median_window;

    assign issue     = ((r_state == S_SUM) || (r_state == S_MSCAN)) && (r_iss != r_win);
    assign ram_raddr = (r_state == S_MCAND) ? r_cptr : r_rptr;

    wamf_ram #(
        .WIDTH (DATA_W),
        .DEPTH (DEPTH)
    ) u_hist (
        .i_clk   (i_clk),
        .i_we    (in_accept),
        .i_waddr (in_wp),
        .i_wdata (i_s_axis_tdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    assign rem_s   = {r_rem, r_acc[ACC_W-1]};
    assign med_k   = r_win >> 1;
    assign less_eq = {1'b0, r_less} + {1'b0, r_eq};
    assign med_hit = (r_less <= med_k) && ({1'b0, med_k} < less_eq);

    // Decide at the input beat whether the sample needs a sequencer pass.
    always_comb begin
        n_res    = i_s_axis_tdata;
        n_latest = 1'b0;
        n_state  = S_OUT;
        if (r_filter_mode == MODE_AVG) begin
            if (r_avg_window == '0) begin
                n_res = '0;
            end else if (CNT_W'(in_fill_n) < CNT_W'(r_avg_window)) begin
                n_latest = 1'b1;
            end else begin
                n_state = S_SUM;
            end
        end else if (r_filter_mode == MODE_MEDIAN) begin
            if (med_win == '0) begin
                n_res = '0;
            end else if (CNT_W'(in_fill_n) < CNT_W'(med_win)) begin
                n_latest = 1'b1;
            end else begin
                n_state = S_MCAND;
            end
        end
    end

    always_comb begin
        alu_a   = '0;
        alu_b   = '0;
        alu_sub = 1'b0;
        unique case (r_state)
            S_SUM: begin
                alu_a = {r_acc[ACC_W-1], r_acc};
                alu_b = {{(ACC_W + 1 - DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
            end
            S_ABS, S_SIGN: begin
                alu_b   = {r_acc[ACC_W-1], r_acc};
                alu_sub = 1'b1;
            end
            S_DIV: begin
                alu_a   = {{(ACC_W - WIN_W){1'b0}}, rem_s};
                alu_b   = {{(ACC_W + 1 - WIN_W){1'b0}}, r_win};
                alu_sub = 1'b1;
            end
            S_MSCAN: begin
                alu_a   = {{(ACC_W + 1 - DATA_W){ram_rdata[DATA_W-1]}}, ram_rdata};
                alu_b   = {{(ACC_W + 1 - DATA_W){r_cand[DATA_W-1]}}, r_cand};
                alu_sub = 1'b1;
            end
            default: begin
                alu_a = '0;
            end
        endcase
        alu_y = alu_sub ? (alu_a - alu_b) : (alu_a + alu_b);
    end

    assign out_free = !r_out_valid || i_m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_wp        <= '0;
            r_fill      <= '0;
            r_dv        <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_dv <= issue;
            if (issue) begin
                r_rptr <= older_slot(r_rptr);
                r_iss  <= r_iss + WIN_W'(1);
            end
            if (r_out_valid && i_m_axis_tready && (r_state != S_OUT)) begin
                r_out_valid <= 1'b0;
            end

            unique case (r_state)
                S_IDLE: begin
                    if (in_accept) begin
                        r_wp     <= (in_wp == ADDR_W'(DEPTH - 1)) ? '0 : in_wp + ADDR_W'(1);
                        r_fill   <= in_fill_n;
                        r_newest <= in_wp;
                        r_res    <= n_res;
                        r_latest <= n_latest;
                        r_win    <= (r_filter_mode == MODE_MEDIAN) ? med_win : r_avg_window;
                        r_iss    <= '0;
                        r_rcv    <= '0;
                        r_rptr   <= in_wp;
                        r_cptr   <= in_wp;
                        r_acc    <= '0;
                        r_state  <= n_state;
                    end
                end
                S_SUM: begin
                    if (r_dv) begin
                        r_acc <= alu_y[ACC_W-1:0];
                        r_rcv <= r_rcv + WIN_W'(1);
                    end
                    if (r_rcv == r_win) begin
                        r_state <= S_ABS;
                    end
                end
                S_ABS: begin
                    // Divide the magnitude so the quotient truncates toward zero.
                    r_neg   <= r_acc[ACC_W-1];
                    r_acc   <= r_acc[ACC_W-1] ? alu_y[ACC_W-1:0] : r_acc;
                    r_rem   <= '0;
                    r_bit   <= BIT_W'(ACC_W - 1);
                    r_state <= S_DIV;
                end
                S_DIV: begin
                    // Restoring division, one quotient bit per cycle.
                    if (!alu_y[ACC_W]) begin
                        r_rem <= alu_y[WIN_W-1:0];
                    end else begin
                        r_rem <= rem_s[WIN_W-1:0];
                    end
                    r_acc <= {r_acc[ACC_W-2:0], !alu_y[ACC_W]};
                    if (r_bit == '0) begin
                        r_state <= S_SIGN;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                S_SIGN: begin
                    r_res   <= r_neg ? alu_y[DATA_W-1:0] : r_acc[DATA_W-1:0];
                    r_state <= S_OUT;
                end
                S_MCAND: begin
                    r_state <= S_MLOAD;
                end
                S_MLOAD: begin
                    r_cand  <= ram_rdata;
                    r_rptr  <= r_newest;
                    r_iss   <= '0;
                    r_rcv   <= '0;
                    r_less  <= '0;
                    r_eq    <= '0;
                    r_state <= S_MSCAN;
                end
                S_MSCAN: begin
                    // Count window entries below and equal to the candidate.
                    if (r_dv) begin
                        r_rcv <= r_rcv + WIN_W'(1);
                        if (alu_y[ACC_W]) begin
                            r_less <= r_less + WIN_W'(1);
                        end
                        if (ram_rdata == r_cand) begin
                            r_eq <= r_eq + WIN_W'(1);
                        end
                    end
                    if (r_rcv == r_win) begin
                        if (med_hit) begin
                            r_res   <= r_cand;
                            r_state <= S_OUT;
                        end else begin
                            r_cptr  <= older_slot(r_cptr);
                            r_state <= S_MCAND;
                        end
                    end
                end
                S_OUT: begin
                    if (out_free) begin
                        r_out_valid  <= 1'b1;
                        r_out_data   <= r_res;
                        r_out_latest <= r_latest;
                        r_state      <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    assign o_m_axis_tvalid   = r_out_valid;
    assign o_m_axis_tdata    = r_out_data;
    assign o_m_axis_tuser[0] = r_out_latest;

    // Configuration port
    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_filter_mode   <= MODE_PASS;
            r_avg_window    <= WIN_W'(1);
            r_median_window <= WIN_W'(1);
        end else if (cfg_wr) begin
            if (reg_idx == REG_FILTER_MODE) begin
                r_filter_mode <= pwdata[MODE_W-1:0];
            end
            if (reg_idx == REG_AVG_WINDOW) begin
                r_avg_window <= pwdata[WIN_W-1:0];
            end
            if (reg_idx == REG_MEDIAN_WINDOW) begin
                r_median_window <= pwdata[WIN_W-1:0];
            end
        end
    end

    always_comb begin
        prdata = '0;
        if (reg_idx == REG_FILTER_MODE) begin
            prdata = {{(APB_DATA_W - MODE_W){1'b0}}, r_filter_mode};
        end else if (reg_idx == REG_AVG_WINDOW) begin
            prdata = {{(APB_DATA_W - WIN_W){1'b0}}, r_avg_window};
        end else if (reg_idx == REG_MEDIAN_WINDOW) begin
            prdata = {{(APB_DATA_W - WIN_W){1'b0}}, r_median_window};
        end
    end

endmodule

`default_nettype wire

### sv/wamf_ram.sv
// ============================================================================
// wamf_ram
// Generic single-write, single-read RAM with a registered read port.
// ============================================================================
`default_nettype none

module wamf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

### test/tb_window_average_median_filter.sv
// ============================================================================
// tb_window_average_median_filter
// Self-checking bench for the window average / median filter.
// ============================================================================
// Samples go in on the input stream and results come back on the output
// stream. A predictor in the bench keeps its own ring of samples and its own
// copy of the three registers, and works out the expected result for every
// accepted sample. The monitor compares each result beat with the oldest
// expectation. Directed beats cover the sample extremes, every mode, zero
// windows, too-short history and window clamping. Random phases follow with
// changing register settings, random idling on both sides and a long stall.
// ============================================================================

module tb_window_average_median_filter;

    timeunit 1ns;
    timeprecision 1ps;

    import wamf_pkg::*;

    localparam logic [MODE_W-1:0] MODE_SPARE = MODE_W'(3);
    localparam int RANDOM_BEATS = 40;
    localparam int HOLD_CYCLES  = 300;

    typedef struct {
        logic [31:0] sample;
        logic        restart;
    } t_sample_beat;

    typedef struct packed {
        logic [31:0] filtered;
        logic        used_latest;
    } t_filt_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic [31:0] s_tdata = '0;
    logic [0:0]  s_tuser = '0;
    logic        m_tready = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [APB_ADDR_W-1:0] paddr = '0;
    logic [APB_DATA_W-1:0] pwdata = '0;

    wire logic        s_tready;
    wire logic        m_tvalid;
    wire logic [31:0] m_tdata;
    wire logic [0:0]  m_tuser;
    wire logic [APB_DATA_W-1:0] prdata;
    wire logic        pready;

    window_average_median_filter u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),    // sample[31:0]
        .i_s_axis_tuser  (s_tuser),    // restart[0]
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),    // filtered[31:0]
        .o_m_axis_tuser  (m_tuser),    // used_latest[0]
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Predictor state: sample ring and register copies.
    int          hist_ring[DEPTH];
    int          ring_wr_pos = 0;
    int          ring_fill = 0;
    logic [MODE_W-1:0] cfg_mode = MODE_PASS;
    logic [7:0]  cfg_avg_win = 8'd1;
    logic [7:0]  cfg_med_win = 8'd1;

    t_sample_beat sample_beats[$];
    t_filt_result expected_outputs[$];
    int beats_queued = 0;
    int beats_taken = 0;
    int mismatches = 0;
    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_done = 0;
    int hold_left = 0;

    function automatic t_filt_result predict_filter_output(input logic [31:0] smp,
                                                           input logic restart);
        t_filt_result res;
        longint acc;
        int vals[DEPTH];
        int win, k, j, v, pos;
        if (restart) begin
            foreach (hist_ring[i]) hist_ring[i] = 0;
            ring_wr_pos = 0;
            ring_fill = 0;
        end
        hist_ring[ring_wr_pos] = smp;
        ring_wr_pos = (ring_wr_pos == DEPTH - 1) ? 0 : ring_wr_pos + 1;
        if (ring_fill < DEPTH) ring_fill++;

        res.filtered = smp;
        res.used_latest = 1'b0;
        pos = (ring_wr_pos == 0) ? DEPTH - 1 : ring_wr_pos - 1;
        case (cfg_mode)
            MODE_AVG: begin
                // The average window is not clamped, so above the ring depth
                // the newest sample always comes back.
                win = cfg_avg_win;
                if (win == 0) begin
                    res.filtered = '0;
                end else if (ring_fill < win) begin
                    res.used_latest = 1'b1;
                end else begin
                    acc = 0;
                    for (k = 0; k < win; k++) begin
                        acc += hist_ring[pos];
                        pos = (pos == 0) ? DEPTH - 1 : pos - 1;
                    end
                    res.filtered = 32'(acc / longint'(win));
                end
            end
            MODE_MEDIAN: begin
                win = (cfg_med_win > DEPTH) ? DEPTH : cfg_med_win;
                if (win == 0) begin
                    res.filtered = '0;
                end else if (ring_fill < win) begin
                    res.used_latest = 1'b1;
                end else begin
                    for (k = 0; k < win; k++) begin
                        v = hist_ring[pos];
                        j = k;
                        while (j > 0 && vals[j-1] > v) begin
                            vals[j] = vals[j-1];
                            j--;
                        end
                        vals[j] = v;
                        pos = (pos == 0) ? DEPTH - 1 : pos - 1;
                    end
                    res.filtered = vals[win/2];
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // Sender: presents queued beats, idling at random between them.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready) begin
                expected_outputs = {expected_outputs,
                                    predict_filter_output(s_tdata, s_tuser[0])};
                beats_taken++;
            end
            if (!s_tvalid || s_tready) begin
                if (sample_beats.size() > 0 && $urandom_range(99, 0) >= send_idle_pct) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= sample_beats[0].sample;
                    s_tuser  <= sample_beats[0].restart;
                    void'(sample_beats.pop_front());
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off whenever one is asked for.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            m_tready  <= 1'b0;
        end else if (holds_done != holds_asked) begin
            holds_done <= holds_done + 1;
            hold_left  <= HOLD_CYCLES;
            m_tready   <= 1'b0;
        end else begin
            m_tready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Monitor: each result beat against the oldest expectation.
    always @(posedge i_clk) begin
        t_filt_result want;
        if (i_rst_n && m_tvalid && m_tready) begin
            if (expected_outputs.size() == 0) begin
                $display("%0t ns: result beat with nothing expected: filtered=%h used_latest=%b",
                         $time, m_tdata, m_tuser[0]);
                mismatches++;
            end else begin
                want = expected_outputs.pop_front();
                if (m_tdata !== want.filtered) begin
                    $display("%0t ns: filtered expected %h actual %h",
                             $time, want.filtered, m_tdata);
                    mismatches++;
                end
                if (m_tuser[0] !== want.used_latest) begin
                    $display("%0t ns: used_latest expected %b actual %b",
                             $time, want.used_latest, m_tuser[0]);
                    mismatches++;
                end
            end
        end
    end

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= APB_DATA_W'(value);
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_FILTER_MODE:   cfg_mode = value[MODE_W-1:0];
            REG_AVG_WINDOW:    cfg_avg_win = value;
            REG_MEDIAN_WINDOW: cfg_med_win = value;
            default: ;
        endcase
    endtask

    // Waits until the block is idle so the registers may be rewritten.
    task automatic drain();
        while (beats_taken != beats_queued || expected_outputs.size() != 0)
            @(negedge i_clk);
    endtask

    task automatic set_filter(input logic [MODE_W-1:0] mode, input logic [7:0] avg_win,
                              input logic [7:0] med_win);
        drain();
        write_reg(REG_FILTER_MODE, 8'(mode));
        write_reg(REG_AVG_WINDOW, avg_win);
        write_reg(REG_MEDIAN_WINDOW, med_win);
        @(negedge i_clk);
    endtask

    task automatic queue_beat(input logic [31:0] smp, input logic restart);
        t_sample_beat b;
        b.sample = smp;
        b.restart = restart;
        sample_beats = {sample_beats, b};
        beats_queued++;
    endtask

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(9, 0))
            0: begin
                case ($urandom_range(3, 0))
                    0: return 32'h7fff_ffff;
                    1: return 32'h8000_0000;
                    2: return 32'h0000_0000;
                    default: return 32'hffff_ffff;
                endcase
            end
            // Small values make ties in the median likely.
            1, 2: return 32'($signed($urandom_range(16, 0)) - 8);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [7:0] pick_window();
        int r;
        r = $urandom_range(19, 0);
        if (r == 0) return 8'd0;
        if (r == 1) return 8'd255;
        if (r <= 3) return 8'($urandom_range(255, 65));
        if (r == 4) return 8'(DEPTH);
        return 8'($urandom_range(12, 1));
    endfunction

    initial begin
        int n_random;
        int n_phase;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        send_idle_pct = 15;
        recv_idle_pct = 49;

        // Pass through at reset settings; the long hold backs up the input.
        holds_asked++;
        queue_beat(32'h7fff_ffff, 1'b0);
        queue_beat(32'h8000_0000, 1'b1);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'hffff_ffff, 1'b0);
        queue_beat(32'h0001_8000, 1'b0);

        set_filter(MODE_SPARE, 8'd3, 8'd3);
        queue_beat(32'h1234_5678, 1'b0);
        queue_beat(32'hfedc_ba98, 1'b1);

        // Zero window, oversized window, then a short average with truncation.
        set_filter(MODE_AVG, 8'd0, 8'd1);
        queue_beat(32'h0fff_0000, 1'b0);
        set_filter(MODE_AVG, 8'd255, 8'd1);
        queue_beat(32'h0000_1000, 1'b0);
        set_filter(MODE_AVG, 8'd3, 8'd1);
        queue_beat(32'hffff_ffff, 1'b1);
        queue_beat(32'hffff_ffff, 1'b0);
        queue_beat(32'h0000_0000, 1'b0);
        queue_beat(32'h7fff_ffff, 1'b0);
        queue_beat(32'h7fff_ffff, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);

        // Median: zero window, short history, ties, single entry.
        set_filter(MODE_MEDIAN, 8'd1, 8'd0);
        queue_beat(32'h0000_0005, 1'b0);
        set_filter(MODE_MEDIAN, 8'd1, 8'd4);
        queue_beat(32'h0000_0007, 1'b1);
        queue_beat(32'hffff_fffe, 1'b0);
        queue_beat(32'h0000_0007, 1'b0);
        queue_beat(32'h8000_0000, 1'b0);
        queue_beat(32'h7fff_ffff, 1'b0);
        set_filter(MODE_MEDIAN, 8'd1, 8'd1);
        queue_beat(32'h0000_0003, 1'b0);

        // Fill the whole ring under a full-depth average.
        set_filter(MODE_AVG, 8'(DEPTH), 8'd1);
        queue_beat(pick_sample(), 1'b1);
        repeat (DEPTH + 2) queue_beat(pick_sample(), 1'b0);

        send_idle_pct = 49;
        recv_idle_pct = 15;

        // An oversized median window is clamped to the full ring.
        set_filter(MODE_MEDIAN, 8'd255, 8'd255);
        repeat (3) queue_beat(pick_sample(), 1'b0);
        set_filter(MODE_AVG, 8'd255, 8'd255);
        queue_beat(pick_sample(), 1'b0);

        n_random = 0;
        while (n_random < RANDOM_BEATS) begin
            if (n_random >= RANDOM_BEATS / 2 && send_idle_pct != 0) begin
                drain();
                send_idle_pct = 0;
                recv_idle_pct = 0;
                holds_asked++;
            end
            set_filter(MODE_W'($urandom_range(3, 0)), pick_window(), pick_window());
            n_phase = $urandom_range(16, 6);
            for (int k = 0; k < n_phase; k++) begin
                queue_beat(pick_sample(),
                           (k == 0) ? ($urandom_range(3, 0) == 0) : ($urandom_range(11, 0) == 0));
                n_random++;
            end
        end

        drain();
        repeat (100) @(posedge i_clk);
        if (mismatches == 0) begin
            $display("window_average_median_filter: match");
        end else begin
            $display("window_average_median_filter: mismatch");
        end
        $finish;
    end

    initial begin
        #50_000_000;
        $display("window_average_median_filter: mismatch");
        $finish;
    end

endmodule
